>>> rtl/crc8_checked_command_packet_receiver_unit_defines.svh
// ----------------------------------------------------------------------------
// crc8 command packet receiver: assertion macros
// concurrent checks that can be compiled out by defining ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef CRC8_CHECKED_COMMAND_PACKET_RECEIVER_UNIT_DEFINES_SVH
`define CRC8_CHECKED_COMMAND_PACKET_RECEIVER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_SAME(label, clock, rstn, ante, cons)
`define ASSERT_NEXT(label, clock, rstn, ante, cons)

`endif

`endif

>>> rtl/crc8cpr_pkg.sv
// ----------------------------------------------------------------------------
// crc8cpr_pkg
// types, constants and the crc-8 step shared by the packet receiver
// ----------------------------------------------------------------------------
`default_nettype none

package crc8cpr_pkg;

	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] CRC_INIT   = 8'h00;
	localparam logic [3:0] PAYLOAD_LEN = 4'd8;
	localparam logic [3:0] CHECK_POS  = 4'd8;   // position of the check byte
	localparam logic [3:0] COUNT_MAX  = 4'd15;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_CRC_ERR = 2'd1,
		STATUS_LEN_ERR = 2'd2
	} status_t;

	// msb-first crc-8 over one byte, unrolled bit by bit
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/crc8_checked_command_packet_receiver_unit.sv
// ----------------------------------------------------------------------------
// crc8_checked_command_packet_receiver_unit
// assembles 9-byte command packets (two little-endian words and a crc-8 byte)
// ----------------------------------------------------------------------------
// Takes one byte per cycle, back to back. Each accepted byte is registered,
// then in the next cycle folded into the running crc and the word being
// assembled; the combinational unrolled crc-8 step sets that rate. A byte
// flagged as last gives one result, held in the result register: status
// 0 with the new words when the check byte matches, status 1 with both words
// zeroed on a crc mismatch, status 2 with the words unchanged for any length
// other than nine. Other bytes give no result. Input is held back only while
// a final byte waits behind a result that has not been taken.
`default_nettype none

`include "crc8_checked_command_packet_receiver_unit_defines.svh"

module crc8_checked_command_packet_receiver_unit
	import crc8cpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        data_valid,
	output logic             data_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [1:0]       status,
	output logic [31:0]      turn_rate_bits,
	output logic [31:0]      forward_speed_bits
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// packet state
	logic [3:0]  byte_count_q;
	logic [7:0]  crc_q;
	logic [31:0] first_word_q;
	logic [31:0] second_word_q;
	logic [31:0] held_turn_q;
	logic [31:0] held_speed_q;

	// result register
	logic        out_valid_q;
	status_t     out_status_q;
	logic [31:0] out_turn_q;
	logic [31:0] out_speed_q;

	logic        s1_fire;
	logic        in_fire;
	logic        end_fire;
	logic        len_ok;
	logic        crc_ok;
	logic [31:0] lane_word;
	logic [7:0]  crc_next;
	status_t     status_next;
	logic [31:0] turn_next;
	logic [31:0] speed_next;

	// a final byte needs a free result slot, other bytes never wait
	assign s1_fire    = valid_s1 && (!last_s1 || !out_valid_q || result_ready);
	assign data_ready = !valid_s1 || s1_fire;
	assign in_fire    = data_valid && data_ready;
	assign end_fire   = s1_fire && last_s1;

	assign lane_word = {24'd0, byte_s1} << {byte_count_q[1:0], 3'b000};
	assign crc_next  = crc8_byte(crc_q, byte_s1);
	assign len_ok    = (byte_count_q == CHECK_POS);
	assign crc_ok    = (byte_s1 == crc_q);

	always_comb begin
		priority if (len_ok && crc_ok) begin
			status_next = STATUS_OK;
			turn_next   = first_word_q;
			speed_next  = second_word_q;
		end else if (len_ok) begin
			status_next = STATUS_CRC_ERR;
			turn_next   = '0;
			speed_next  = '0;
		end else begin
			status_next = STATUS_LEN_ERR;
			turn_next   = held_turn_q;
			speed_next  = held_speed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			crc_q         <= CRC_INIT;
			first_word_q  <= '0;
			second_word_q <= '0;
			held_turn_q   <= '0;
			held_speed_q  <= '0;
		end else if (s1_fire) begin
			if (last_s1) begin
				byte_count_q  <= '0;
				crc_q         <= CRC_INIT;
				first_word_q  <= '0;
				second_word_q <= '0;
				held_turn_q   <= turn_next;
				held_speed_q  <= speed_next;
			end else begin
				if (byte_count_q < PAYLOAD_LEN) begin
					crc_q <= crc_next;
					if (!byte_count_q[2]) begin
						first_word_q <= first_word_q | lane_word;
					end else begin
						second_word_q <= second_word_q | lane_word;
					end
				end
				if (byte_count_q != COUNT_MAX) begin
					byte_count_q <= byte_count_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (end_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_fire) begin
			out_status_q <= status_next;
			out_turn_q   <= turn_next;
			out_speed_q  <= speed_next;
		end
	end

	assign result_valid       = out_valid_q;
	assign status             = out_status_q;
	assign turn_rate_bits     = out_turn_q;
	assign forward_speed_bits = out_speed_q;

	`ASSERT_NEXT(a_end_clears_count, clk, arst_n, end_fire, byte_count_q == 4'd0)
	`ASSERT_NEXT(a_mismatch_zeroes, clk, arst_n, end_fire && len_ok && !crc_ok,
		held_turn_q == 32'd0 && held_speed_q == 32'd0)
	`ASSERT_SAME(a_stall_cause, clk, arst_n, !data_ready,
		valid_s1 && last_s1 && out_valid_q && !result_ready)
	`ASSERT_NEXT(a_result_follows_end, clk, arst_n, end_fire, out_valid_q)

endmodule

`default_nettype wire
